@@ hw/rtl/fsi_pkg.sv @@
// Shared types and codes for the fuzzy speed inference unit.
`timescale 1ns / 1ps
package fsi_pkg;

	localparam int unsigned DEG_ONE = 32768;

	typedef enum logic [1:0] {
		FUNC_SET  = 2'd0,
		FUNC_RULE = 2'd1,
		FUNC_EVAL = 2'd2,
		FUNC_NOP  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		SHAPE_TRI  = 2'd0,
		SHAPE_FALL = 2'd1,
		SHAPE_RISE = 2'd2,
		SHAPE_NONE = 2'd3
	} shape_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RULE,
		ST_TERM,
		ST_SLOPE,
		ST_DIV,
		ST_GRADE,
		ST_ACC,
		ST_FDIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [3:0]  entry_index;
		logic [15:0] set_left;
		logic [15:0] set_middle;
		logic [15:0] set_right;
		logic [1:0]  set_shape;
		logic [20:0] rule_word;
		logic [15:0] front_distance;
		logic [15:0] near_side_distance;
		logic [15:0] far_side_distance;
	} in_item_t;

	typedef struct packed {
		logic [15:0] target_speed;
		logic [18:0] total_firing;
		logic        none_fired;
	} out_item_t;

	typedef struct packed {
		logic [15:0] left;
		logic [15:0] middle;
		logic [15:0] right;
		logic [1:0]  shape;
	} mset_t;

	// divider command between sequencer and shared divider
	typedef struct packed {
		logic        start;
		logic [41:0] num;
		logic [22:0] den;
	} div_cmd_t;

	typedef struct packed {
		logic        done;
		logic [41:0] quot;
	} div_rsp_t;

endpackage

@@ hw/rtl/fsi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fsi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ hw/rtl/fsi_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module fsi_div (
	input  logic             clk,
	input  logic             arst_n,
	input  fsi_pkg::div_cmd_t cmd,
	output fsi_pkg::div_rsp_t rsp
);
	import fsi_pkg::*;

	localparam int NW = 42;
	localparam int DW = 23;

	logic [NW-1:0]        quot_q;
	logic [DW:0]          rem_q;
	logic [DW-1:0]        den_q;
	logic [$clog2(NW):0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DW:0]          shifted;
	logic [DW:0]          diff;

	assign shifted = {rem_q[DW-1:0], quot_q[NW-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ($clog2(NW)+1)'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ($clog2(NW)+1)'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quot_q <= cmd.num;
			rem_q  <= '0;
			den_q  <= cmd.den;
		end else if (busy_q) begin
			if (!diff[DW]) begin
				rem_q  <= diff;
				quot_q <= {quot_q[NW-2:0], 1'b1};
			end else begin
				rem_q  <= shifted;
				quot_q <= {quot_q[NW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
endmodule

@@ hw/rtl/fsi_seq.sv @@
// Sequencer: table writes, rule and term walk, slope grading, accumulation, final division and output.
`timescale 1ns / 1ps
module fsi_seq #(
	parameter int NUM_FAMILIES    = 3,
	parameter int SETS_PER_FAMILY = 3,
	parameter int MAX_RULES       = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  fsi_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output fsi_pkg::out_item_t out_data,
	input  logic [3:0]         rules_in_use,
	output fsi_pkg::div_cmd_t  div_cmd,
	input  fsi_pkg::div_rsp_t  div_rsp
);
	import fsi_pkg::*;

	localparam int NUM_SETS = NUM_FAMILIES * SETS_PER_FAMILY;
	localparam int SW       = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int RW       = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int CW       = $clog2(MAX_RULES + 1);
	localparam int TW       = 16 + CW + 1;

	state_t state_q, state_d;

	logic [15:0]   crisp_q [3];
	logic [CW-1:0] count_q;
	logic [CW-1:0] rule_q;
	logic [1:0]    term_q;
	logic          side_q;
	logic [20:0]   word_q;
	logic [16:0]   res_q;
	logic [16:0]   up_q;
	logic [16:0]   slope_q;
	logic [TW-1:0] total_q;
	logic [TW+7:0] wsum_q;
	logic          busy_q;
	out_item_t     out_q;
	logic          out_valid_q;

	logic          ms_we;
	logic [SW-1:0] ms_raddr;
	logic [49:0]   ms_rdata;
	logic          rl_we;
	logic [RW-1:0] rl_raddr;
	logic [20:0]   rl_rdata;
	mset_t         ms;

	logic [20:0]   word_cur;
	logic [3:0]    term_idx;
	logic          term_ok;
	logic [15:0]   tval;
	logic [15:0]   pa;
	logic          dir_up;
	logic [16:0]   num;
	logic [16:0]   den;
	logic          den_neg;
	logic          num_neg;
	logic [16:0]   num_abs;
	logic [16:0]   den_abs;
	logic [16:0]   quick;
	logic          quick_ok;
	logic [16:0]   deg;
	logic [16:0]   merged;
	logic          accept;
	logic [CW-1:0] count_sat;
	logic [16:0]   qclamp;

	assign accept   = in_valid && !in_stall;
	assign in_stall = busy_q || out_valid_q;
	assign ms_we    = accept && func_t'(in_data.func) == FUNC_SET
		&& {1'b0, in_data.entry_index} < 5'(NUM_SETS);
	assign rl_we    = accept && func_t'(in_data.func) == FUNC_RULE
		&& {1'b0, in_data.entry_index} < 5'(MAX_RULES);

	fsi_ram #(.WIDTH(50), .DEPTH(NUM_SETS)) u_ms (
		.clk(clk), .we(ms_we), .waddr(in_data.entry_index[SW-1:0]),
		.wdata({in_data.set_left, in_data.set_middle, in_data.set_right,
			in_data.set_shape}),
		.raddr(ms_raddr), .rdata(ms_rdata));

	fsi_ram #(.WIDTH(21), .DEPTH(MAX_RULES)) u_rl (
		.clk(clk), .we(rl_we), .waddr(in_data.entry_index[RW-1:0]),
		.wdata(in_data.rule_word), .raddr(rl_raddr), .rdata(rl_rdata));

	assign ms = mset_t'(ms_rdata);
	assign rl_raddr = rule_q[RW-1:0];

	assign word_cur = (state_q == ST_TERM && term_q == 2'd0 && !side_q) ? rl_rdata : word_q;

	always_comb begin
		unique case (term_q)
			2'd0:    term_idx = word_cur[3:0];
			2'd1:    term_idx = word_cur[7:4];
			default: term_idx = word_cur[11:8];
		endcase
	end
	assign term_ok  = {1'b0, term_idx} < 5'(NUM_SETS);
	assign ms_raddr = term_idx[SW-1:0];
	assign tval     = crisp_q[term_q];

	assign count_sat = ({1'b0, rules_in_use} > 5'(MAX_RULES)) ? CW'(MAX_RULES)
		: CW'(rules_in_use);

	// slope: side 0 rising (left), side 1 falling (right)
	assign dir_up  = !side_q;
	assign pa      = side_q ? ms.right : ms.left;
	assign num     = {1'b0, tval} - {1'b0, pa};
	assign den     = {1'b0, ms.middle} - {1'b0, pa};
	assign num_neg = num[16];
	assign den_neg = den[16];
	assign num_abs = num_neg ? (~num + 17'd1) : num;
	assign den_abs = den_neg ? (~den + 17'd1) : den;

	always_comb begin
		quick_ok = 1'b1;
		quick    = '0;
		if (den == '0) begin
			if (dir_up) quick = (tval >= pa) ? 17'(DEG_ONE) : '0;
			else quick = (tval <= pa) ? 17'(DEG_ONE) : '0;
		end else if (num == '0 || num_neg != den_neg) begin
			quick = '0;
		end else if (num_abs >= den_abs) begin
			quick = 17'(DEG_ONE);
		end else begin
			quick_ok = 1'b0;
		end
	end

	assign qclamp = 17'(div_rsp.quot);

	always_comb begin
		unique case (shape_t'(ms.shape))
			SHAPE_TRI:  deg = (up_q < slope_q) ? up_q : slope_q;
			SHAPE_FALL: deg = slope_q;
			SHAPE_RISE: deg = up_q;
			default:    deg = '0;
		endcase
	end

	always_comb begin
		if (term_q == 2'd0) merged = deg;
		else if (word_q[12]) merged = (deg > res_q) ? deg : res_q;
		else merged = (deg < res_q) ? deg : res_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept && func_t'(in_data.func) == FUNC_EVAL) state_d = ST_RULE;
			ST_RULE:  state_d = (rule_q == count_q) ? ST_FDIV : ST_TERM;
			ST_TERM:  state_d = ST_SLOPE;
			ST_SLOPE: state_d = (!term_ok || quick_ok) ? ST_GRADE : ST_DIV;
			ST_DIV:   if (div_rsp.done) state_d = ST_GRADE;
			ST_GRADE: state_d = ST_ACC;
			ST_ACC:   state_d = ST_RULE;
			ST_FDIV:  if (total_q == '0 || div_rsp.done) state_d = ST_OUT;
			ST_OUT:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		div_cmd.start = 1'b0;
		div_cmd.num   = 42'(num_abs) << 15;
		div_cmd.den   = 23'(den_abs);
		if (state_q == ST_SLOPE && !quick_ok && term_ok) begin
			div_cmd.start = 1'b1;
		end
		if (state_q == ST_RULE && rule_q == count_q && total_q != '0) begin
			div_cmd.start = 1'b1;
			div_cmd.num   = 42'({wsum_q, 8'd0}) + 42'(total_q >> 1);
			div_cmd.den   = 23'(total_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (accept && func_t'(in_data.func) == FUNC_EVAL) busy_q <= 1'b1;
			if (state_q == ST_OUT) begin
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end
		end
	end

	// Walk: RULE issues rule read; TERM latches word on first term;
	// SLOPE evaluates one side of one term; GRADE merges after both sides.
	always_ff @(posedge clk) begin
		if (accept) begin
			crisp_q[0] <= in_data.front_distance;
			crisp_q[1] <= in_data.near_side_distance;
			crisp_q[2] <= in_data.far_side_distance;
			count_q    <= count_sat;
			rule_q     <= '0;
			term_q     <= 2'd0;
			side_q     <= 1'b0;
			total_q    <= '0;
			wsum_q     <= '0;
		end
		unique case (state_q)
			ST_TERM: if (term_q == 2'd0 && !side_q) word_q <= rl_rdata;
			ST_SLOPE: begin
				if (quick_ok) begin
					if (side_q) slope_q <= quick;
					else up_q <= quick;
				end
			end
			ST_DIV: if (div_rsp.done) begin
				if (side_q) slope_q <= (qclamp > 17'(DEG_ONE)) ? 17'(DEG_ONE) : qclamp;
				else up_q <= (qclamp > 17'(DEG_ONE)) ? 17'(DEG_ONE) : qclamp;
			end
			ST_GRADE: begin
				if (!side_q) begin
					side_q <= 1'b1;
				end else begin
					side_q <= 1'b0;
					if (term_q == 2'd0 && !term_ok) res_q <= '0;
					else if (term_q == 2'd0 || term_ok) res_q <= merged;
					term_q <= (term_q == 2'd2) ? 2'd0 : term_q + 2'd1;
				end
			end
			ST_ACC: begin
				if (term_q == 2'd0 && !side_q) begin
					total_q <= total_q + TW'(res_q);
					wsum_q  <= wsum_q + (TW+8)'(res_q) * (TW+8)'(word_q[20:13]);
					rule_q  <= rule_q + 1'b1;
				end
			end
			ST_FDIV: begin
				out_q.total_firing <= (total_q > TW'(19'h7FFFF)) ? 19'h7FFFF : 19'(total_q);
				out_q.none_fired   <= (total_q == '0);
				out_q.target_speed <= (total_q == '0) ? 16'd0 : 16'(div_rsp.quot);
			end
			default: ;
		endcase
	end

	// GRADE with side 0 only advances to the second side; ACC returns to RULE
	// after every side and adds up a rule once its last term is graded.
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

@@ hw/rtl/fuzzy_speed_inference_unit.sv @@
// Top level of the fuzzy speed inference unit: config register and core.
//
// channel | direction | handshake       | payload
// in      | input     | in_valid/stall  | fsi_pkg::in_item_t
// out     | output    | out_valid/stall | fsi_pkg::out_item_t
// cfg     | input     | valid/ready     | rules_in_use, 4 bits
//
// An evaluate runs six slope passes per rule in use (three terms, two sides);
// a pass uses the shared bit-serial divider when the slope needs it. A final
// division forms the target speed; it is skipped when nothing fired.
// Reset clears control state; the tables are undefined until written.
// The input stalls while an evaluate runs or a result waits.
`timescale 1ns / 1ps
module fuzzy_speed_inference_unit #(
	parameter int NUM_FAMILIES    = 3,
	parameter int SETS_PER_FAMILY = 3,
	parameter int MAX_RULES       = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  fsi_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output fsi_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_data
);
	import fsi_pkg::*;

	logic [3:0] rules_q;
	div_cmd_t   div_cmd;
	div_rsp_t   div_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rules_q <= 4'd7;
		else if (cfg_valid && cfg_ready) rules_q <= cfg_data;
	end

	fsi_seq #(.NUM_FAMILIES(NUM_FAMILIES), .SETS_PER_FAMILY(SETS_PER_FAMILY),
		.MAX_RULES(MAX_RULES)) u_seq (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data), .rules_in_use(rules_q), .div_cmd(div_cmd),
		.div_rsp(div_rsp));

	fsi_div u_div (.clk(clk), .arst_n(arst_n), .cmd(div_cmd), .rsp(div_rsp));

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("accept while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.none_fired == (out_data.total_firing == 19'd0)))
		else $error("none_fired mismatch");
endmodule
